// ----- hdl/brr_pkg.sv -----
// Shared types and constants for the bordered rectangle rasterizer.
// Used by the front end, the queue, the scan back end and the top level.
package brr_pkg;

  localparam int unsigned MaxSide   = 4096;
  localparam int unsigned SideW     = 13;   // image size incl. value 4096
  localparam int unsigned PixW      = 12;   // pixel index bits
  localparam int unsigned IdxW      = 22;   // saturated signed index
  localparam int unsigned DvdW      = 46;   // dividend magnitude bits
  localparam int unsigned DenW      = 33;   // divisor magnitude bits
  localparam int unsigned DivSteps  = DvdW;
  localparam int unsigned CntW      = 6;
  localparam int unsigned ColW      = 32;
  localparam int unsigned ThkW      = 13;
  localparam int unsigned InDataW   = 208;
  localparam int unsigned OutDataW  = 56;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam logic [IdxW-1:0] IdxSat = IdxW'(1 << 20);

  typedef enum logic [CfgIdxW-1:0] {
    REG_IMG_W  = 3'd0,
    REG_IMG_H  = 3'd1,
    REG_WX_MIN = 3'd2,
    REG_WX_MAX = 3'd3,
    REG_WY_MIN = 3'd4,
    REG_WY_MAX = 3'd5
  } reg_idx_e;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  // One entry of the queue between front and back end
  typedef struct packed {
    func_e                  kind;
    logic                   empty;
    logic signed [IdxW-1:0] row_lo;
    logic signed [IdxW-1:0] row_hi;
    logic signed [IdxW-1:0] col_lo;
    logic signed [IdxW-1:0] col_hi;
    logic [ColW-1:0]        inner;
    logic [ColW-1:0]        edge_col;
    logic [ThkW-1:0]        thick;
  } cmd_t;

  function automatic logic [SideW-1:0] clamp_side(input logic [SideW-1:0] s);
    clamp_side = (s > SideW'(MaxSide)) ? SideW'(MaxSide) : s;
  endfunction

endpackage

// ----- hdl/bordered_rectangle_rasterizer.sv -----
// Top level of the bordered rectangle rasterizer: configuration registers,
// front end, command queue and scan back end. Depends on brr_pkg.
//
//  channel  | direction | handshake          | payload
//  s_axis   | in        | tvalid/tready      | tuser=func, tdata=corners,colors,width
//  m_axis   | out       | tvalid/tready      | tdata=row,col,color, tlast=last pixel
//  cfg      | in        | cfg_valid/ready    | cfg_index, cfg_data
//
// Ticks stream from the queue at one pixel per cycle while the output is not stalled.
// A box load maps its four corners one after another in the shared bit-serial divider.
// Reset clears the configuration to its defaults and leaves no box loaded.
// The two-entry queue and the output register let either side stall alone.
module bordered_rectangle_rasterizer import brr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: corner_x_a, corner_x_b, corner_y_a, corner_y_b, inner_color,
  //        edge_color, edge_thickness, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tuser: func
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: pixel_row, pixel_col, pixel_color
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic [SideW-1:0] img_w_q, img_h_q;
  logic signed [31:0] wx_min_q, wx_max_q, wy_min_q, wy_max_q;
  logic push, full, pop, empty;
  cmd_t cmd_in, cmd_out;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q  <= SideW'(1024);
      img_h_q  <= SideW'(1024);
      wx_min_q <= '0;
      wx_max_q <= 32'sd67108864;
      wy_min_q <= '0;
      wy_max_q <= 32'sd67108864;
    end else if (cfg_valid) begin
      case (reg_idx_e'(cfg_index))
        REG_IMG_W:  img_w_q  <= cfg_data[SideW-1:0];
        REG_IMG_H:  img_h_q  <= cfg_data[SideW-1:0];
        REG_WX_MIN: wx_min_q <= cfg_data;
        REG_WX_MAX: wx_max_q <= cfg_data;
        REG_WY_MIN: wy_min_q <= cfg_data;
        REG_WY_MAX: wy_max_q <= cfg_data;
        default: ;
      endcase
    end
  end

  brr_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .func_i     (func_e'(s_axis_tuser)),
    .in_data_i  (s_axis_tdata),
    .img_w_i    (img_w_q),
    .img_h_i    (img_h_q),
    .wx_min_i   (wx_min_q),
    .wx_max_i   (wx_max_q),
    .wy_min_i   (wy_min_q),
    .wy_max_i   (wy_max_q),
    .push_o     (push),
    .cmd_o      (cmd_in),
    .full_i     (full)
  );

  brr_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (cmd_out)
  );

  brr_back u_back (
    .clk_i, .rst_ni,
    .empty_i     (empty),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .img_w_i     (img_w_q),
    .img_h_i     (img_h_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ----- hdl/brr_fifo.sv -----
// Two-entry command queue decoupling the front end from the scan back end.
// Depends on brr_pkg for the entry type.
module brr_fifo import brr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t data_o
);

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");

endmodule

// ----- hdl/brr_front.sv -----
// Front end: accepts items, maps box corners to pixel indices with a
// shared bit-serial divider and queues commands. Depends on brr_pkg.
module brr_front import brr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  func_e                  func_i,
  input  logic [InDataW-1:0]     in_data_i,
  input  logic [SideW-1:0]       img_w_i,
  input  logic [SideW-1:0]       img_h_i,
  input  logic signed [31:0]     wx_min_i,
  input  logic signed [31:0]     wx_max_i,
  input  logic signed [31:0]     wy_min_i,
  input  logic signed [31:0]     wy_max_i,
  output logic                   push_o,
  output cmd_t                   cmd_o,
  input  logic                   full_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_PUSH = 4'b1000
  } state_e;

  state_e st_q, st_d;
  logic [1:0] sel_q, sel_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic signed [31:0] corner_q [4];
  logic [ColW-1:0] inner_q, edge_q;
  logic [ThkW-1:0] thick_q;
  logic empty_q;
  logic signed [IdxW-1:0] res_q [4];
  logic [DvdW-1:0] dvd_q, dvd_d;
  logic [DenW-1:0] den_q, den_d, rem_q, rem_d;
  logic [DvdW-1:0] quo_q, quo_d;
  logic neg_q, neg_d;

  logic accept, zero_span;
  logic signed [33:0] num;
  logic signed [32:0] span;
  logic [SideW-1:0]   side;
  logic signed [47:0] prod;
  logic [47:0]        prod_mag;
  logic [32:0]        span_mag;
  logic [DenW:0]      rem_t;
  logic               qbit;
  logic [DvdW-1:0]    quo_n;
  logic [IdxW-1:0]    mag_sat;
  logic signed [IdxW-1:0] res_n;

  assign accept    = in_valid_i && in_ready_o;
  assign zero_span = (wx_max_i == wx_min_i) || (wy_max_i == wy_min_i);
  assign in_ready_o = (st_q == S_IDLE) && !(func_i == FUNC_TICK && full_i);

  // operand selection for the current corner coordinate
  always_comb begin
    if (!sel_q[1]) begin
      num  = 34'(corner_q[sel_q]) - 34'(wx_min_i);
      span = 33'(wx_max_i) - 33'(wx_min_i);
      side = clamp_side(img_w_i);
    end else begin
      num  = (34'(wy_max_i) - 34'(corner_q[sel_q])) - 34'(wy_min_i);
      span = 33'(wy_max_i) - 33'(wy_min_i);
      side = clamp_side(img_h_i);
    end
    prod     = 48'(num) * $signed({35'd0, side});
    prod_mag = prod[47] ? 48'(-prod) : 48'(prod);
    span_mag = span[32] ? 33'(-span) : 33'(span);
  end

  // one restoring division step
  always_comb begin
    rem_t   = {rem_q, dvd_q[DvdW-1]};
    qbit    = (rem_t >= {1'b0, den_q});
    quo_n   = {quo_q[DvdW-2:0], qbit};
    mag_sat = (quo_n > DvdW'(IdxSat)) ? IdxSat : quo_n[IdxW-1:0];
    res_n   = neg_q ? IdxW'(-$signed(mag_sat)) : $signed(mag_sat);
  end

  // sequencer
  always_comb begin
    st_d  = st_q;
    sel_d = sel_q;
    cnt_d = cnt_q;
    dvd_d = dvd_q;
    den_d = den_q;
    rem_d = rem_q;
    quo_d = quo_q;
    neg_d = neg_q;
    push_o = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (accept && func_i == FUNC_TICK) begin
          push_o = 1'b1;
        end else if (accept) begin
          sel_d = 2'd0;
          st_d  = zero_span ? S_PUSH : S_MUL;
        end
      end
      S_MUL: begin
        dvd_d = prod_mag[DvdW-1:0];
        den_d = span_mag;
        neg_d = prod[47] ^ span[32];
        rem_d = '0;
        quo_d = '0;
        cnt_d = '0;
        st_d  = S_DIV;
      end
      S_DIV: begin
        dvd_d = {dvd_q[DvdW-2:0], 1'b0};
        rem_d = qbit ? DenW'(rem_t - {1'b0, den_q}) : rem_t[DenW-1:0];
        quo_d = quo_n;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          sel_d = sel_q + 1'b1;
          st_d  = (sel_q == 2'd3) ? S_PUSH : S_MUL;
        end
      end
      S_PUSH: begin
        if (!full_i) begin
          push_o = 1'b1;
          st_d   = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // command to the queue
  always_comb begin
    cmd_o.kind     = (st_q == S_IDLE) ? FUNC_TICK : FUNC_LOAD;
    cmd_o.empty    = empty_q;
    cmd_o.row_lo   = (res_q[2] < res_q[3]) ? res_q[2] : res_q[3];
    cmd_o.row_hi   = (res_q[2] < res_q[3]) ? res_q[3] : res_q[2];
    cmd_o.col_lo   = (res_q[0] < res_q[1]) ? res_q[0] : res_q[1];
    cmd_o.col_hi   = (res_q[0] < res_q[1]) ? res_q[1] : res_q[0];
    cmd_o.inner    = inner_q;
    cmd_o.edge_col = edge_q;
    cmd_o.thick    = thick_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      sel_q <= 2'd0;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      sel_q <= sel_d;
      cnt_q <= cnt_d;
    end
  end

  // payload: load operands, divider datapath, mapped indices
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
    if (st_q == S_IDLE && accept && func_i == FUNC_LOAD) begin
      corner_q[0] <= in_data_i[31:0];
      corner_q[1] <= in_data_i[63:32];
      corner_q[2] <= in_data_i[95:64];
      corner_q[3] <= in_data_i[127:96];
      inner_q     <= in_data_i[159:128];
      edge_q      <= in_data_i[191:160];
      thick_q     <= in_data_i[204:192];
      empty_q     <= zero_span;
    end
    if (st_q == S_DIV && cnt_q == CntW'(DivSteps - 1)) begin
      res_q[sel_q] <= res_n;
    end
  end

endmodule

// ----- hdl/brr_back.sv -----
// Back end: holds the current box and walks it in row-major order, one
// pixel per tick, into an output register. Depends on brr_pkg.
module brr_back import brr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  cmd_t                cmd_i,
  output logic                pop_o,
  input  logic [SideW-1:0]    img_w_i,
  input  logic [SideW-1:0]    img_h_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o,
  output logic                out_last_o
);

  logic signed [IdxW-1:0] rlo_q, rhi_q, clo_q, chi_q;
  logic [PixW-1:0] row_q, col_q;
  logic [ColW-1:0] inner_q, edge_q;
  logic [ThkW-1:0] thick_q;
  logic active_q;
  logic ov_q;
  logic [OutDataW-1:0] od_q;
  logic ol_q;

  logic slot_free, take, emit;
  logic signed [23:0] w_s, h_s, r_s, c_s, d0, d1, d2, d3, dmin;
  logic signed [23:0] rs, re, cs, ce, re_t, ce_t, cs_t;
  logic is_edge, wrap, done;

  assign slot_free = !ov_q || out_ready_i;
  assign take  = !empty_i && slot_free;
  assign pop_o = take;
  assign emit  = take && cmd_i.kind == FUNC_TICK && active_q;

  // bounds for a new box and for the current tick
  always_comb begin
    w_s  = $signed({11'd0, clamp_side(img_w_i)});
    h_s  = $signed({11'd0, clamp_side(img_h_i)});
    rs   = (cmd_i.row_lo > 0) ? 24'(cmd_i.row_lo) : 24'sd0;
    re   = (24'(cmd_i.row_hi) < h_s) ? 24'(cmd_i.row_hi) : h_s;
    cs   = (cmd_i.col_lo > 0) ? 24'(cmd_i.col_lo) : 24'sd0;
    ce   = (24'(cmd_i.col_hi) < w_s) ? 24'(cmd_i.col_hi) : w_s;
    r_s  = $signed({12'd0, row_q});
    c_s  = $signed({12'd0, col_q});
    d0   = r_s - 24'(rlo_q);
    d1   = 24'(rhi_q) - 24'sd1 - r_s;
    d2   = c_s - 24'(clo_q);
    d3   = 24'(chi_q) - 24'sd1 - c_s;
    dmin = d0;
    if (d1 < dmin) dmin = d1;
    if (d2 < dmin) dmin = d2;
    if (d3 < dmin) dmin = d3;
    is_edge = dmin < $signed({11'd0, thick_q});
    re_t = ((24'(rhi_q) < h_s) ? 24'(rhi_q) : h_s) - 24'sd1;
    ce_t = ((24'(chi_q) < w_s) ? 24'(chi_q) : w_s) - 24'sd1;
    cs_t = (clo_q > 0) ? 24'(clo_q) : 24'sd0;
    wrap = c_s >= ce_t;
    done = wrap && (r_s >= re_t);
  end

  // box and scan position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      rlo_q <= '0; rhi_q <= '0; clo_q <= '0; chi_q <= '0;
      row_q <= '0; col_q <= '0;
      inner_q <= '0; edge_q <= '0; thick_q <= '0;
    end else if (take && cmd_i.kind == FUNC_LOAD) begin
      inner_q <= cmd_i.inner;
      edge_q  <= cmd_i.edge_col;
      thick_q <= cmd_i.thick;
      if (cmd_i.empty) begin
        rlo_q <= '0; rhi_q <= '0; clo_q <= '0; chi_q <= '0;
        row_q <= '0; col_q <= '0;
        active_q <= 1'b0;
      end else begin
        rlo_q <= cmd_i.row_lo;
        rhi_q <= cmd_i.row_hi;
        clo_q <= cmd_i.col_lo;
        chi_q <= cmd_i.col_hi;
        row_q <= rs[PixW-1:0];
        col_q <= cs[PixW-1:0];
        active_q <= (rs < re) && (cs < ce);
      end
    end else if (emit) begin
      if (done) begin
        active_q <= 1'b0;
      end else if (wrap) begin
        row_q <= row_q + 1'b1;
        col_q <= cs_t[PixW-1:0];
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (slot_free) begin
      ov_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      od_q <= {(is_edge ? edge_q : inner_q), col_q, row_q};
      ol_q <= done;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign out_last_o  = ol_q;

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && done) |=> !active_q) else $error("scan still active after last pixel");
  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> slot_free) else $error("pixel emitted over a pending one");
  a_inactive_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> !emit) else $error("pixel emitted with no box");

endmodule

// ----- test/brr_checker.sv -----
// Checker for the bordered rectangle rasterizer: watches the input, output and
// configuration channels, predicts each pixel write and compares it.
// Depends on brr_pkg for widths, register indexes and item kinds.
module brr_checker import brr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                m_axis_tlast,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  pixels_pending_o,
  output int                  fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PixW-1:0] row;
    logic [PixW-1:0] col;
    logic [ColW-1:0] color;
    logic            last;
  } pixel_t;

  pixel_t pixel_q[$];

  // shadow configuration
  logic [SideW-1:0] img_w, img_h;
  longint wx_lo, wx_hi, wy_lo, wy_hi;
  // shadow scan state
  longint row_lo, row_hi, col_lo, col_hi, cur_row, cur_col;
  logic [ColW-1:0] fill_clr, border_clr;
  logic [ThkW-1:0] border_w;
  bit scanning;

  assign pixels_pending_o = pixel_q.size();

  function automatic longint side_of(logic [SideW-1:0] s);
    side_of = (s > SideW'(MaxSide)) ? longint'(MaxSide) : longint'(s);
  endfunction

  function automatic longint map_index(longint sz, longint num, longint den);
    longint v;
    v = (sz * num) / den;
    if (v > (64'sd1 << 20)) v = 64'sd1 << 20;
    if (v < -(64'sd1 << 20)) v = -(64'sd1 << 20);
    map_index = v;
  endfunction

  function automatic longint lmin(longint a, longint b);
    lmin = (a < b) ? a : b;
  endfunction

  function automatic longint lmax(longint a, longint b);
    lmax = (a > b) ? a : b;
  endfunction

  // Box load: map corners, order them, latch colours, find first pixel
  task automatic load_box(logic [InDataW-1:0] d);
    longint w, h, sx, sy, c1, c2, r1, r2;
    w  = side_of(img_w);
    h  = side_of(img_h);
    sx = wx_hi - wx_lo;
    sy = wy_hi - wy_lo;
    fill_clr   = d[159:128];
    border_clr = d[191:160];
    border_w   = d[204:192];
    scanning   = 0;
    if (sx == 0 || sy == 0) begin
      row_lo = 0; row_hi = 0; col_lo = 0; col_hi = 0; cur_row = 0; cur_col = 0;
      return;
    end
    c1 = map_index(w, longint'($signed(d[31:0])) - wx_lo, sx);
    c2 = map_index(w, longint'($signed(d[63:32])) - wx_lo, sx);
    r1 = map_index(h, (wy_hi - longint'($signed(d[95:64]))) - wy_lo, sy);
    r2 = map_index(h, (wy_hi - longint'($signed(d[127:96]))) - wy_lo, sy);
    row_lo = lmin(r1, r2); row_hi = lmax(r1, r2);
    col_lo = lmin(c1, c2); col_hi = lmax(c1, c2);
    cur_row = lmax(row_lo, 0);
    cur_col = lmax(col_lo, 0);
    scanning = (cur_row < lmin(row_hi, h)) && (cur_col < lmin(col_hi, w));
  endtask

  // Tick: emit the current pixel and step in row-major order
  task automatic tick_box();
    longint edge_gap, rend, cend;
    pixel_t p;
    if (!scanning) return;
    edge_gap = lmin(lmin(cur_row - row_lo, row_hi - 1 - cur_row),
                    lmin(cur_col - col_lo, col_hi - 1 - cur_col));
    p.row   = cur_row[PixW-1:0];
    p.col   = cur_col[PixW-1:0];
    p.color = (edge_gap < longint'(border_w)) ? border_clr : fill_clr;
    p.last  = 0;
    rend = lmin(row_hi, side_of(img_h)) - 1;
    cend = lmin(col_hi, side_of(img_w)) - 1;
    if (cur_col >= cend) begin
      if (cur_row >= rend) begin
        p.last = 1;
        scanning = 0;
      end else begin
        cur_row = cur_row + 1;
        cur_col = lmax(col_lo, 0);
      end
    end else begin
      cur_col = cur_col + 1;
    end
    pixel_q.push_back(p);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t got, want;
    if (!rst_ni) begin
      img_w = 1024; img_h = 1024;
      wx_lo = 0; wx_hi = 64'sd1024 << 16; wy_lo = 0; wy_hi = 64'sd1024 << 16;
      row_lo = 0; row_hi = 0; col_lo = 0; col_hi = 0; cur_row = 0; cur_col = 0;
      fill_clr = '0; border_clr = '0; border_w = '0; scanning = 0;
      pixel_q.delete();
      fail_count_o = 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_e'(cfg_index))
          REG_IMG_W:  img_w = cfg_data[SideW-1:0];
          REG_IMG_H:  img_h = cfg_data[SideW-1:0];
          REG_WX_MIN: wx_lo = longint'($signed(cfg_data));
          REG_WX_MAX: wx_hi = longint'($signed(cfg_data));
          REG_WY_MIN: wy_lo = longint'($signed(cfg_data));
          REG_WY_MAX: wy_hi = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      // input transfers
      if (s_axis_tvalid && s_axis_tready) begin
        if (func_e'(s_axis_tuser) == FUNC_LOAD) load_box(s_axis_tdata);
        else tick_box();
      end
      // output transfers
      if (m_axis_tvalid && m_axis_tready) begin
        got.row   = m_axis_tdata[11:0];
        got.col   = m_axis_tdata[23:12];
        got.color = m_axis_tdata[55:24];
        got.last  = m_axis_tlast;
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected pixel row=%0d col=%0d color=%h last=%0b",
                   $time, got.row, got.col, got.color, got.last);
          fail_count_o++;
        end else begin
          want = pixel_q.pop_front();
          if (got.row !== want.row) begin
            $display("%0t: row expected %0d actual %0d", $time, want.row, got.row);
            fail_count_o++;
          end
          if (got.col !== want.col) begin
            $display("%0t: col expected %0d actual %0d", $time, want.col, got.col);
            fail_count_o++;
          end
          if (got.color !== want.color) begin
            $display("%0t: color expected %h actual %h", $time, want.color, got.color);
            fail_count_o++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

// ----- test/tb_bordered_rectangle_rasterizer.sv -----
// Testbench top for the bordered rectangle rasterizer: clock, reset, box and
// tick stimulus over several register settings, and the verdict.
// Depends on brr_pkg, the rasterizer RTL and brr_checker.
module tb_bordered_rectangle_rasterizer;
  import brr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SettleCycles = 400;      // covers a box load in the divider
  localparam longint      CycleLimit   = 3000000;

  logic                clk_i = 0;
  logic                rst_ni = 0;
  logic                s_axis_tvalid = 0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_valid = 0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  int                  pixels_pending, fail_count;

  int unsigned src_idle_pct = 20, snk_idle_pct = 81;
  longint cycles = 0;
  // current mapping, mirrored for aiming boxes
  longint map_w = 1024, map_h = 1024;
  longint wx0 = 0, wx1 = 64'sd1024 << 16, wy0 = 0, wy1 = 64'sd1024 << 16;

  bordered_rectangle_rasterizer u_dut (.*);

  brr_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .pixels_pending_o(pixels_pending), .fail_count_o(fail_count)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL bordered_rectangle_rasterizer");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic send(func_e kind, logic [InDataW-1:0] d);
    int gap;
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 0;
      gap = $urandom_range(4, 1);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1;
    s_axis_tuser  = kind;
    s_axis_tdata  = d;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 0;
  endtask

  function automatic logic [InDataW-1:0] pack_box(logic [31:0] xa, logic [31:0] xb,
      logic [31:0] ya, logic [31:0] yb, logic [31:0] fill, logic [31:0] brd,
      logic [ThkW-1:0] thk);
    pack_box = {3'b000, thk, brd, fill, yb, ya, xb, xa};
  endfunction

  task automatic load(logic [31:0] xa, logic [31:0] xb, logic [31:0] ya,
                      logic [31:0] yb, logic [ThkW-1:0] thk);
    send(FUNC_LOAD, pack_box(xa, xb, ya, yb, $urandom, $urandom, thk));
  endtask

  task automatic ticks(int n);
    repeat (n) send(FUNC_TICK, InDataW'({$urandom, $urandom, $urandom, $urandom,
                                         $urandom, $urandom, $urandom}));
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 0;
  endtask

  // idle point: every expected pixel seen and any box load finished
  task automatic drain();
    while (pixels_pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_map(logic [12:0] w, logic [12:0] h, logic [31:0] x0,
                         logic [31:0] x1, logic [31:0] y0, logic [31:0] y1);
    drain();
    write_reg(REG_IMG_W, 32'(w));
    write_reg(REG_IMG_H, 32'(h));
    write_reg(REG_WX_MIN, x0);
    write_reg(REG_WX_MAX, x1);
    write_reg(REG_WY_MIN, y0);
    write_reg(REG_WY_MAX, y1);
    map_w = (w > 4096) ? 4096 : w;
    map_h = (h > 4096) ? 4096 : h;
    wx0 = $signed(x0); wx1 = $signed(x1); wy0 = $signed(y0); wy1 = $signed(y1);
  endtask

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    clip32 = v[31:0];
  endfunction

  // world coordinates that land near a chosen pixel column / row
  function automatic logic [31:0] world_x(longint p);
    world_x = clip32(wx0 + ((wx1 - wx0) * p + (wx1 - wx0) / 2) / (map_w == 0 ? 1 : map_w));
  endfunction

  function automatic logic [31:0] world_y(longint p);
    world_y = clip32(wy1 - wy0 - ((wy1 - wy0) * p + (wy1 - wy0) / 2) / (map_h == 0 ? 1 : map_h));
  endfunction

  // Random part: mostly aimed small boxes followed by their ticks
  task automatic random_boxes(int n_items);
    int sent, kind, n;
    longint c, r, cw, rh;
    logic [ThkW-1:0] thk;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      thk = ($urandom_range(9) == 0) ? ThkW'($urandom) : ThkW'($urandom_range(4));
      if (kind < 75) begin
        c  = longint'($urandom_range(32'(map_w + 6))) - 3;
        r  = longint'($urandom_range(32'(map_h + 6))) - 3;
        cw = $urandom_range(6);
        rh = $urandom_range(6);
        if ($urandom_range(1)) load(world_x(c), world_x(c + cw), world_y(r), world_y(r + rh), thk);
        else load(world_x(c + cw), world_x(c), world_y(r + rh), world_y(r), thk);
      end else if (kind < 90) begin
        load($urandom, $urandom, $urandom, $urandom, thk);
      end else begin
        load($urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff, $urandom,
             $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000, $urandom, thk);
      end
      n = $urandom_range(45);
      ticks(n);
      sent += n + 1;
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1;
    repeat (2) @(negedge clk_i);

    // directed, default mapping: one pixel per 1.0 world unit
    ticks(1);                                            // tick with no box
    load(32'h0000_0000, 32'h0003_0000, 32'h0400_0000, 32'h03fd_0000, 0);
    ticks(10);                                           // 3x3 plain fill, then idle tick
    load(32'h0004_0000, 32'h0000_0000, 32'h03fc_0000, 32'h0400_0000, 1);
    ticks(4);                                            // bordered, corners swapped
    load(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 13'd4096);
    ticks(3);                                            // saturated, clipped box
    load(32'h0005_0000, 32'h0005_0000, 32'h0100_0000, 32'h00f0_0000, 2);
    ticks(1);                                            // zero width
    load(32'hffff_0000, 32'hfff0_0000, 32'h0100_0000, 32'h00f0_0000, 2);
    ticks(1);                                            // left of the image

    // first third: sender idles a little, receiver a lot
    random_boxes(200);
    set_map(13'd4096, 13'd4096, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    random_boxes(180);
    src_idle_pct = 81; snk_idle_pct = 20;
    set_map(13'd1, 13'd1, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
    random_boxes(100);
    set_map(13'h1fff, 13'd0, 32'h0010_0000, 32'h0000_0000, 32'hffff_0000, 32'h0001_0000);
    random_boxes(100);
    set_map(13'd17, 13'd9, 32'h0123_0000, 32'h0123_0000, 32'h0000_0000, 32'h0009_0000);
    random_boxes(80);
    src_idle_pct = 0; snk_idle_pct = 0;
    set_map(13'd23, 13'd11, 32'hfff0_8000, 32'h0007_4000, 32'h0005_0000, 32'hfffa_0000);
    random_boxes(250);
    set_map(13'd1024, 13'd1024, 32'h0000_0000, 32'h0400_0000, 32'h0000_0000, 32'h0400_0000);
    random_boxes(220);

    drain();
    if (fail_count == 0) begin
      $display("PASS bordered_rectangle_rasterizer");
    end else begin
      $display("FAIL bordered_rectangle_rasterizer");
    end
    $finish;
  end

endmodule
